// ===== rtl/core/bm25ts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm25ts_pkg
// Widths, register indexes, config bundle and the length decode for the
// BM25 term scorer.
// ----------------------------------------------------------------------------
package bm25ts_pkg;

  localparam int FREQ_W   = 32;
  localparam int CODE_W   = 8;
  localparam int SCORE_W  = 32;
  localparam int K_W      = 16;
  localparam int BLEND_W  = 17;
  localparam int AVG_W    = 48;
  localparam int WEIGHT_W = 32;
  localparam int LEN_W    = 32;
  localparam int N_W      = 48;
  localparam int CFG_DW   = 48;
  localparam int CFG_IW   = 2;
  localparam int RDIV_W   = 63;   // quotient bits of the length ratio divide
  localparam int SDIV_W   = 32;   // quotient bits of the score divide
  localparam int INNER_W  = 64;

  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;
  localparam logic [N_W-1:0]     NORM_MAX  = {N_W{1'b1}};

  localparam logic [K_W-1:0]      K_ONE_RST  = 16'd4915;
  localparam logic [BLEND_W-1:0]  BLEND_RST  = 17'd49152;
  localparam logic [AVG_W-1:0]    AVG_RST    = 48'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 32'd16777216;

  typedef enum logic [CFG_IW-1:0] {
    REG_K_ONE  = 2'd0,
    REG_BLEND  = 2'd1,
    REG_AVG    = 2'd2,
    REG_WEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [K_W-1:0]     k_one;
    logic [BLEND_W-1:0] blend;   // already clamped to one
    logic [AVG_W-1:0]   avg_len;
  } norm_cfg_t;

  // Length ROM: linear below 24, then 3-bit mantissa with a shifted exponent.
  function automatic logic [LEN_W-1:0] decode_length(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] j;
    logic [4:0]        ex;
    logic [LEN_W-1:0]  mant;
    logic [LEN_W-1:0]  res;
    j    = code - CODE_W'(24);
    ex   = j[7:3];
    mant = LEN_W'({1'b1, j[2:0]});
    if (code < CODE_W'(24)) begin
      res = LEN_W'(code);
    end else if (ex == 5'd0) begin
      res = LEN_W'(24) + LEN_W'(j[2:0]);
    end else begin
      res = LEN_W'(24) + (mant << (ex - 5'd1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bm25ts_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm25ts_in_if
// Posting channel: valid/ready with term frequency and norm byte.
// ----------------------------------------------------------------------------
interface bm25ts_in_if;
  logic                           valid;
  logic                           ready;
  logic [bm25ts_pkg::FREQ_W-1:0]  freq;
  logic [bm25ts_pkg::CODE_W-1:0]  norm_code;

  modport source (output valid, freq, norm_code, input ready);
  modport sink   (input valid, freq, norm_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bm25ts_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm25ts_out_if
// Score channel: valid/ready with the posting score.
// ----------------------------------------------------------------------------
interface bm25ts_out_if;
  logic                           valid;
  logic                           ready;
  logic [bm25ts_pkg::SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bm25_term_scorer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm25_term_scorer_top
// BM25 posting scorer: score = floor(weight*freq/(freq+n)), Q8.24.
// ----------------------------------------------------------------------------
//  channel   dir  fields                      transfer
//  in_i      in   freq[31:0] norm_code[7:0]   valid & ready
//  out_o     out  score[31:0]                 valid & ready
//  cfg       in   cfg_idx_i cfg_data_i        cfg_we_i
//
//  One posting per cycle while out_o is not stalled. Stages: in the norm pipe,
//  decode, 63 restoring divide steps, three multiply/sum stages; here, the
//  numerator stage, 32 divide steps, output register. The divides are most of it.
//  Reset clears valid bits and loads the register defaults.
//  A stall on out_o freezes every stage; in_i.ready follows it.
// ----------------------------------------------------------------------------
module bm25_term_scorer_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  bm25ts_in_if.sink                          in_i,
  bm25ts_out_if.source                       out_o,
  input  wire                                cfg_we_i,
  input  wire [bm25ts_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  wire [bm25ts_pkg::CFG_DW-1:0]       cfg_data_i
);
  import bm25ts_pkg::*;

  // configuration
  logic [K_W-1:0]      k_one_q;
  logic [BLEND_W-1:0]  blend_q;
  logic [AVG_W-1:0]    avg_q;
  logic [WEIGHT_W-1:0] weight_q;
  norm_cfg_t           ncfg;

  // pipeline control: whole pipe moves when output slot frees
  logic adv;

  logic              nv;
  logic [FREQ_W-1:0] nf;
  logic [N_W-1:0]    nn;

  // score divide: index 0 is the numerator stage
  logic              sv_q   [0:SDIV_W];
  logic              sz_q   [0:SDIV_W];
  logic [N_W:0]      sd_q   [0:SDIV_W];
  logic [N_W:0]      srem_q [0:SDIV_W];
  logic [SDIV_W-1:0] sqn_q  [0:SDIV_W];
  logic [N_W:0]      srem_d [0:SDIV_W-1];
  logic [SDIV_W-1:0] sqn_d  [0:SDIV_W-1];
  logic [N_W:0]      dsum;
  logic [63:0]       wprod;

  logic               ov_q;
  logic [SCORE_W-1:0] score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_one_q  <= K_ONE_RST;
      blend_q  <= BLEND_RST;
      avg_q    <= AVG_RST;
      weight_q <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_K_ONE:  k_one_q  <= cfg_data_i[K_W-1:0];
        REG_BLEND:  blend_q  <= cfg_data_i[BLEND_W-1:0];
        REG_AVG:    avg_q    <= cfg_data_i[AVG_W-1:0];
        REG_WEIGHT: weight_q <= cfg_data_i[WEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  // b above one behaves as one
  assign ncfg.k_one   = k_one_q;
  assign ncfg.blend   = (blend_q > BLEND_ONE) ? BLEND_ONE : blend_q;
  assign ncfg.avg_len = avg_q;

  assign adv        = !ov_q || out_o.ready;
  assign in_i.ready = adv;

  bm25ts_norm_pipe u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .freq_i  (in_i.freq),
    .code_i  (in_i.norm_code),
    .cfg_i   (ncfg),
    .valid_o (nv),
    .freq_o  (nf),
    .n_o     (nn)
  );

  // freq <= freq+n, so the quotient fits 32 bits and the top half of the
  // numerator seeds the remainder.
  assign dsum  = (N_W+1)'(nf) + (N_W+1)'(nn);
  assign wprod = weight_q * nf;

  always_comb begin
    for (int i = 0; i < SDIV_W; i++) begin
      logic [N_W+1:0] t;
      t = {srem_q[i], sqn_q[i][SDIV_W-1]};
      if (t >= {1'b0, sd_q[i]}) begin
        srem_d[i] = (N_W+1)'(t - {1'b0, sd_q[i]});
        sqn_d[i]  = {sqn_q[i][SDIV_W-2:0], 1'b1};
      end else begin
        srem_d[i] = t[N_W:0];
        sqn_d[i]  = {sqn_q[i][SDIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SDIV_W; i++) sv_q[i] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= nv;
      for (int i = 0; i < SDIV_W; i++) sv_q[i+1] <= sv_q[i];
      ov_q <= sv_q[SDIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sz_q[0]   <= (dsum == '0);
      sd_q[0]   <= dsum;
      srem_q[0] <= (N_W+1)'(wprod[63:32]);
      sqn_q[0]  <= wprod[31:0];
      for (int i = 0; i < SDIV_W; i++) begin
        sz_q[i+1]   <= sz_q[i];
        sd_q[i+1]   <= sd_q[i];
        srem_q[i+1] <= srem_d[i];
        sqn_q[i+1]  <= sqn_d[i];
      end
      // zero denominator scores zero
      score_q <= sz_q[SDIV_W] ? '0 : sqn_q[SDIV_W];
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.score = score_q;

  a_score_le_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.score <= weight_q)
    else $error("score above weight");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sv_q[0]) && $stable(sv_q[SDIV_W]) && $stable(nv))
    else $error("pipeline moved during stall");

  a_avg_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv && avg_q == '0 |-> nn == NORM_MAX)
    else $error("n not saturated for zero avg_len");

endmodule

`default_nettype wire

// ===== rtl/core/bm25ts_norm_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm25ts_norm_pipe
// Pipelined length normalization n = k1*((1-b)+b*len/avg_len), Q40.8.
// ----------------------------------------------------------------------------
module bm25ts_norm_pipe (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           adv_i,
  input  wire                           valid_i,
  input  wire [bm25ts_pkg::FREQ_W-1:0]  freq_i,
  input  wire [bm25ts_pkg::CODE_W-1:0]  code_i,
  input  wire bm25ts_pkg::norm_cfg_t    cfg_i,
  output logic                          valid_o,
  output logic [bm25ts_pkg::FREQ_W-1:0] freq_o,
  output logic [bm25ts_pkg::N_W-1:0]    n_o
);
  import bm25ts_pkg::*;

  logic [LEN_W-1:0]         len;
  logic [BLEND_W+LEN_W-1:0] bl_len;

  // divide stages: index 0 is the entry stage
  logic                  dv_q   [0:RDIV_W];
  logic [FREQ_W-1:0]     df_q   [0:RDIV_W];
  logic [AVG_W-1:0]      drem_q [0:RDIV_W];
  logic [RDIV_W-1:0]     dqn_q  [0:RDIV_W];
  logic [AVG_W-1:0]      drem_d [0:RDIV_W-1];
  logic [RDIV_W-1:0]     dqn_d  [0:RDIV_W-1];

  logic                  av_q, bv_q, cv_q;
  logic [FREQ_W-1:0]     af_q, bf_q, cf_q;
  logic [INNER_W-1:0]    inner_q;
  logic [K_W+32-1:0]     ph_q, pl_q;
  logic [N_W-1:0]        n_q;
  logic [60:0]           nsum;

  assign len    = decode_length(code_i);
  assign bl_len = cfg_i.blend * len;

  always_comb begin
    for (int i = 0; i < RDIV_W; i++) begin
      logic [AVG_W:0] t;
      t = {drem_q[i], dqn_q[i][RDIV_W-1]};
      if (t >= {1'b0, cfg_i.avg_len}) begin
        drem_d[i] = AVG_W'(t - {1'b0, cfg_i.avg_len});
        dqn_d[i]  = {dqn_q[i][RDIV_W-2:0], 1'b1};
      end else begin
        drem_d[i] = t[AVG_W-1:0];
        dqn_d[i]  = {dqn_q[i][RDIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= RDIV_W; i++) dv_q[i] <= 1'b0;
      av_q <= 1'b0;
      bv_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= valid_i;
      for (int i = 0; i < RDIV_W; i++) dv_q[i+1] <= dv_q[i];
      av_q <= dv_q[RDIV_W];
      bv_q <= av_q;
      cv_q <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      df_q[0]   <= freq_i;
      drem_q[0] <= '0;
      dqn_q[0]  <= {bl_len[46:0], 16'b0};
      for (int i = 0; i < RDIV_W; i++) begin
        df_q[i+1]   <= df_q[i];
        drem_q[i+1] <= drem_d[i];
        dqn_q[i+1]  <= dqn_d[i];
      end
      af_q    <= df_q[RDIV_W];
      inner_q <= INNER_W'(BLEND_ONE - cfg_i.blend) + INNER_W'(dqn_q[RDIV_W]);
      bf_q    <= af_q;
      ph_q    <= cfg_i.k_one * inner_q[63:32];
      pl_q    <= cfg_i.k_one * inner_q[31:0];
      cf_q    <= bf_q;
      n_q     <= (cfg_i.avg_len == '0 || nsum > 61'(NORM_MAX)) ? NORM_MAX : nsum[N_W-1:0];
    end
  end

  assign nsum    = 61'({ph_q, 12'b0}) + 61'(pl_q[47:20]);
  assign valid_o = cv_q;
  assign freq_o  = cf_q;
  assign n_o     = n_q;

endmodule

`default_nettype wire

// ===== verif/bm25_term_scorer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term_scorer_top_tb
// Streams postings through the BM25 term scorer under several register
// settings and checks every score against a bit-exact predictor.
// ----------------------------------------------------------------------------

// Predicts scores and holds them in arrival order.
class bm25_score_board;
  logic [15:0] k1;
  logic [16:0] blend;
  logic [47:0] avg;
  logic [31:0] wgt;
  logic [31:0] pending_scores[$];
  int          errors;
  int          checked;

  function new();
    k1 = 16'd4915; blend = 17'd49152; avg = 48'd65536; wgt = 32'd16777216;
    errors = 0; checked = 0;
  endfunction

  function logic [63:0] doc_length(logic [7:0] code);
    logic [7:0] j;
    j = code - 8'd24;
    if (code < 8'd24) return 64'(code);
    if (j[7:3] == 5'd0) return 64'd24 + 64'(j[2:0]);
    return 64'd24 + (64'({1'b1, j[2:0]}) << (j[7:3] - 1));
  endfunction

  // n = k1 * ((1-b) + b*len/avg) in Q.8, saturated to 48 bits
  function logic [63:0] norm_term(logic [7:0] code);
    logic [63:0] bl, r, inner, prod;
    if (avg == 0) return 64'hFFFF_FFFF_FFFF;
    bl = (blend > 17'd65536) ? 64'd65536 : 64'(blend);
    r = ((bl * doc_length(code)) << 16) / 64'(avg);
    inner = (64'd65536 - bl) + r;
    prod = ((64'(k1) * (inner >> 32)) << 12) + ((64'(k1) * inner[31:0]) >> 20);
    return (prod > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : prod;
  endfunction

  function void note_posting(logic [31:0] freq, logic [7:0] code);
    logic [63:0] d;
    d = 64'(freq) + norm_term(code);
    pending_scores.push_back((d == 0) ? 32'd0 : 32'((64'(wgt) * 64'(freq)) / d));
  endfunction

  function void check_score(logic [31:0] score);
    logic [31:0] exp_score;
    checked++;
    if (pending_scores.size() == 0) begin
      errors++;
      $display("%0t: unexpected score %h", $time, score);
      return;
    end
    exp_score = pending_scores.pop_front();
    if (exp_score !== score) begin
      errors++;
      $display("%0t: score mismatch expected %h actual %h", $time, exp_score, score);
    end
  endfunction
endclass

module bm25_term_scorer_top_tb;
  import bm25ts_pkg::*;

  localparam int LATENCY  = 101;
  localparam int WDOG_MAX = 20000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  bm25ts_in_if  in_ch();
  bm25ts_out_if out_ch();

  bm25_term_scorer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  bm25_score_board sb = new();
  int  postings_sent;
  int  idle_cycles;
  bit  stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input transfers are noted and results checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        sb.note_posting(in_ch.freq, in_ch.norm_code);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_score(out_ch.score);
      end
      // Watchdog: nothing moved for too long.
      if (idle_cycles > WDOG_MAX) begin
        $display("%0t: watchdog expired, %0d scores pending", $time,
                 sb.pending_scores.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver back-pressure: the pattern is redrawn periodically, picking at
  // random either an always-ready stretch or random stalls.
  int stall_cnt;
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 1);
    if (!stall_mode) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Register write while idle.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    case (idx)
      REG_K_ONE:  sb.k1    = val[15:0];
      REG_BLEND:  sb.blend = val[16:0];
      REG_AVG:    sb.avg   = val[47:0];
      REG_WEIGHT: sb.wgt   = val[31:0];
      default: ;
    endcase
  endtask

  // Drive one posting; valid held until the transfer.
  task automatic send_posting(logic [31:0] freq, logic [7:0] code);
    in_ch.valid     <= 1'b1;
    in_ch.freq      <= freq;
    in_ch.norm_code <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    postings_sent++;
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every score has arrived, then let the pipe drain.
  task automatic drain();
    drop_valid();
    while (sb.pending_scores.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 32'h3FFF);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Random postings in bursts with random gaps.
  task automatic random_burst(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_posting(rand_freq(), 8'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] edge_freq[6];
    logic [7:0]  edge_code[6];
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.freq = '0; in_ch.norm_code = '0;
    out_ch.ready = 1'b1;
    stall_mode = 1'b0; stall_cnt = 0; idle_cycles = 0; postings_sent = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: default registers, field extremes and every ROM region.
    edge_freq = '{32'd0, 32'd1, 32'd256, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_7FFF};
    edge_code = '{8'd0, 8'd23, 8'd24, 8'd31, 8'd32, 8'd255};
    foreach (edge_freq[i]) send_posting(edge_freq[i], edge_code[i]);
    foreach (edge_code[i]) send_posting(32'h5555_AAAA, edge_code[i]);
    send_posting(32'hAAAA_5555, 8'hAA);
    send_posting(32'hFFFF_FFFF, 8'h55);
    drain();

    // Zero numerator and denominator: k1 zero and b zero with freq zero.
    write_reg(REG_K_ONE, 48'd0);
    write_reg(REG_BLEND, 48'd0);
    send_posting(32'd0, 8'd0);
    send_posting(32'd0, 8'd255);
    send_posting(32'd5, 8'd200);
    drain();

    // Blend above one is clamped; zero average length saturates n.
    write_reg(REG_K_ONE, 48'hFFFF);
    write_reg(REG_BLEND, 48'h1FFFF);
    write_reg(REG_AVG, 48'd0);
    write_reg(REG_WEIGHT, 48'hFFFF_FFFF);
    send_posting(32'd0, 8'd0);
    send_posting(32'hFFFF_FFFF, 8'd255);
    send_posting(32'd1, 8'd100);
    drain();

    // Random phases over several register settings, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_K_ONE, 48'd4915);   write_reg(REG_BLEND, 48'd49152);
          write_reg(REG_AVG, 48'd65536);    write_reg(REG_WEIGHT, 48'd16777216);
        end
        1: begin
          write_reg(REG_AVG, 48'd1);        write_reg(REG_BLEND, 48'd65536);
        end
        2: write_reg(REG_AVG, 48'hFFFF_FFFF_FFFF);
        3: write_reg(REG_BLEND, 48'd65537);
        default: begin
          write_reg(REG_K_ONE, 48'($urandom()));
          write_reg(REG_BLEND, 48'($urandom_range(0, 131071)));
          write_reg(REG_AVG, {16'($urandom()), 32'($urandom())} >> $urandom_range(0, 47));
          write_reg(REG_WEIGHT, 48'($urandom()));
        end
      endcase
      random_burst(50);
      drain();
    end

    $display("Covered %0d postings, %0d scores checked, across %0d register settings.",
             postings_sent, sb.checked, 11);
    if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
